[rtl/qfu_pkg.sv]
// ============================================================================
// qfu_pkg : shared types and constants for the quick-find union block
// Table sizing, microcode step names, control word and status layouts.
// ============================================================================
package qfu_pkg;

    // Table sizing
    localparam int MaxElems = 256;
    localparam int AddrW    = $clog2(MaxElems);
    localparam int IdW      = AddrW;
    localparam int CountW   = AddrW + 1;

    // Microcode step addresses
    typedef enum logic [2:0] {
        ST_WAIT,
        ST_CHECK,
        ST_RDQ,
        ST_CMP,
        ST_SCAN,
        ST_OUT
    } step_t;

    // Table read address source
    typedef enum logic [1:0] {
        RD_P,
        RD_Q,
        RD_FIRST,
        RD_NEXT
    } rdsel_t;

    // Jump condition select
    typedef enum logic [2:0] {
        CC_ALWAYS,
        CC_ACCEPT,
        CC_BAD,
        CC_SAME,
        CC_LAST,
        CC_OUTFREE
    } cond_t;

    // Datapath control field of a microword
    typedef struct packed {
        logic   take_in;   // input port open
        logic   chk;       // capture index check
        rdsel_t rd_sel;    // table read address
        logic   lat_pid;   // capture id of p
        logic   lat_qid;   // capture id of q
        logic   scan_wr;   // relabel entry coming back from the table
        logic   load_out;  // load the result register
    } ctrl_t;

    // Full microword
    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t jt;         // next step when condition holds
        step_t jf;         // next step otherwise
    } ucode_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic bad;         // an index is out of range
        logic same;        // ids of p and q match
        logic last;        // scan has reached the last entry in use
    } stat_t;

endpackage

[rtl/quick_find_union.sv]
// ============================================================================
// quick_find_union : quick-find union over a table of component ids
// Top level: configuration register, sequencer, datapath, result register.
// ============================================================================
// Each item names elements p and q; if their ids differ, every entry among
// the first element_count entries holding p's id is rewritten to q's id.
// One item at a time. A union with good indices scans the first n entries
// (n = element_count, capped at 256) through the id table, which has one
// read and one write port, one entry per cycle; an already-joined pair
// skips the scan, and an index error skips both id reads and the scan. The result
// sits in an output register, so the next item is taken while it waits.
// After reset every element is its own component; no clearing pass is run.
module quick_find_union
    import qfu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CountW-1:0] cfg_data,
    // input item
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [AddrW-1:0]  elem_p,
    input  logic [AddrW-1:0]  elem_q,
    // result item
    output logic              out_valid,
    input  logic              out_stall,
    output logic              already_joined,
    output logic [IdW-1:0]    old_id_p,
    output logic [IdW-1:0]    id_q,
    output logic              index_error
);

    ctrl_t             ctrl;
    stat_t             stat;
    logic              out_free;
    logic              err;
    logic [IdW-1:0]    pid;
    logic [IdW-1:0]    qid;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_eff;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              joined_reg;
    logic [IdW-1:0]    oldp_reg;
    logic [IdW-1:0]    idq_reg;
    logic              ierr_reg;

    // Element count register, capped at the table size
    assign cfg_ready = 1'b1;
    assign count_eff = (count_reg > CountW'(MaxElems)) ? CountW'(MaxElems) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= CountW'(MaxElems);
        else if (cfg_valid && cfg_ready)
            count_reg <= cfg_data;
    end

    assign in_stall = !ctrl.take_in;
    assign out_free = !out_valid_reg || !out_stall;

    qfu_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    qfu_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (in_valid),
        .elem_p    (elem_p),
        .elem_q    (elem_q),
        .count_eff (count_eff),
        .stat      (stat),
        .err       (err),
        .pid       (pid),
        .qid       (qid)
    );

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_out && out_free)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload; rejected unions report zeros
    always_ff @(posedge clk)
    begin
        if (ctrl.load_out && out_free)
        begin
            joined_reg <= !err && (pid == qid);
            oldp_reg   <= err ? '0 : pid;
            idq_reg    <= err ? '0 : qid;
            ierr_reg   <= err;
        end
    end

    assign out_valid      = out_valid_reg;
    assign already_joined = joined_reg;
    assign old_id_p       = oldp_reg;
    assign id_q           = idq_reg;
    assign index_error    = ierr_reg;

endmodule

[rtl/qfu_seq.sv]
// ============================================================================
// qfu_seq : microcode sequencer
// Step counter, control store and jump-condition select.
// ============================================================================
module qfu_seq
    import qfu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_free,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t  upc_reg;
    step_t  upc_next;
    ucode_t uw;
    logic   cond_hit;

    // Control store
    always_comb
    begin
        uw = '0;
        case (upc_reg)
            ST_WAIT:
            begin
                uw.ctrl.take_in = 1'b1;
                uw.ctrl.rd_sel  = RD_P;
                uw.cond         = CC_ACCEPT;
                uw.jt           = ST_CHECK;
                uw.jf           = ST_WAIT;
            end
            ST_CHECK:
            begin
                uw.ctrl.chk     = 1'b1;
                uw.ctrl.rd_sel  = RD_P;
                uw.cond         = CC_BAD;
                uw.jt           = ST_OUT;
                uw.jf           = ST_RDQ;
            end
            ST_RDQ:
            begin
                uw.ctrl.rd_sel  = RD_Q;
                uw.ctrl.lat_pid = 1'b1;
                uw.cond         = CC_ALWAYS;
                uw.jt           = ST_CMP;
                uw.jf           = ST_CMP;
            end
            ST_CMP:
            begin
                uw.ctrl.rd_sel  = RD_FIRST;
                uw.ctrl.lat_qid = 1'b1;
                uw.cond         = CC_SAME;
                uw.jt           = ST_OUT;
                uw.jf           = ST_SCAN;
            end
            ST_SCAN:
            begin
                uw.ctrl.rd_sel  = RD_NEXT;
                uw.ctrl.scan_wr = 1'b1;
                uw.cond         = CC_LAST;
                uw.jt           = ST_OUT;
                uw.jf           = ST_SCAN;
            end
            ST_OUT:
            begin
                uw.ctrl.rd_sel   = RD_P;
                uw.ctrl.load_out = 1'b1;
                uw.cond          = CC_OUTFREE;
                uw.jt            = ST_WAIT;
                uw.jf            = ST_OUT;
            end
            default:
            begin
                uw.cond = CC_ALWAYS;
                uw.jt   = ST_WAIT;
                uw.jf   = ST_WAIT;
            end
        endcase
    end

    // Condition select
    always_comb
    begin
        case (uw.cond)
            CC_ALWAYS:  cond_hit = 1'b1;
            CC_ACCEPT:  cond_hit = in_valid;
            CC_BAD:     cond_hit = stat.bad;
            CC_SAME:    cond_hit = stat.same;
            CC_LAST:    cond_hit = stat.last;
            CC_OUTFREE: cond_hit = out_free;
            default:    cond_hit = 1'b1;
        endcase
    end

    assign upc_next = cond_hit ? uw.jt : uw.jf;
    assign ctrl     = uw.ctrl;

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= ST_WAIT;
        else
            upc_reg <= upc_next;
    end

endmodule

[rtl/qfu_dpath.sv]
// ============================================================================
// qfu_dpath : table datapath
// Component-id table with one read and one write port, per-entry written
// bits, index check and the relabel compare of the scan.
// ============================================================================
module qfu_dpath
    import qfu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_t             ctrl,
    input  logic              in_valid,
    input  logic [AddrW-1:0]  elem_p,
    input  logic [AddrW-1:0]  elem_q,
    input  logic [CountW-1:0] count_eff,
    output stat_t             stat,
    output logic              err,
    output logic [IdW-1:0]    pid,
    output logic [IdW-1:0]    qid
);

    logic [IdW-1:0]      mem [MaxElems];
    logic [MaxElems-1:0] wrt_reg;       // entry has been written since reset

    logic [AddrW-1:0] p_reg;
    logic [AddrW-1:0] q_reg;
    logic             err_reg;
    logic [IdW-1:0]   pid_reg;
    logic [IdW-1:0]   qid_reg;
    logic [AddrW-1:0] rd_addr;
    logic [AddrW-1:0] rd_addr_reg;
    logic [IdW-1:0]   rd_data_reg;
    logic             rd_wrt_reg;
    logic [IdW-1:0]   rd_id;
    logic             hit_wr;

    // Read address source
    always_comb
    begin
        case (ctrl.rd_sel)
            RD_P:     rd_addr = p_reg;
            RD_Q:     rd_addr = q_reg;
            RD_FIRST: rd_addr = '0;
            RD_NEXT:  rd_addr = rd_addr_reg + AddrW'(1);
            default:  rd_addr = p_reg;
        endcase
    end

    // Unwritten entry reads as its own index
    assign rd_id  = rd_wrt_reg ? rd_data_reg : IdW'(rd_addr_reg);
    assign hit_wr = ctrl.scan_wr && (rd_id == pid_reg);

    // Status to the sequencer
    assign stat.bad  = ({1'b0, p_reg} >= count_eff) || ({1'b0, q_reg} >= count_eff);
    assign stat.same = (rd_id == pid_reg);
    assign stat.last = ({1'b0, rd_addr_reg} == (count_eff - CountW'(1)));

    assign err = err_reg;
    assign pid = pid_reg;
    assign qid = qid_reg;

    // Table memory: registered read, scan write-back
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (hit_wr)
            mem[rd_addr_reg] <= qid_reg;
    end

    // Written bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wrt_reg <= '0;
        else if (hit_wr)
            wrt_reg[rd_addr_reg] <= 1'b1;
    end

    // Operand and read-side registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr;
        rd_wrt_reg  <= wrt_reg[rd_addr];
        if (ctrl.take_in && in_valid)
        begin
            p_reg <= elem_p;
            q_reg <= elem_q;
        end
        if (ctrl.chk)
            err_reg <= stat.bad;
        if (ctrl.lat_pid)
            pid_reg <= rd_id;
        if (ctrl.lat_qid)
            qid_reg <= rd_id;
    end

    // Relabel only happens on a union with good indices
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_wr |-> !err_reg)
        else $error("relabel during a rejected union");

    // Relabel stays inside the entries in use
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_wr |-> ({1'b0, rd_addr_reg} < count_eff))
        else $error("relabel beyond element count");

    // Error flag follows the index check
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.chk |=> (err_reg == $past(stat.bad)))
        else $error("error flag lost index check");

endmodule
